@@ hdl/bilinear_image_scaler_defines.svh @@
// Assertion macros of the bilinear image scaler, used by the checker bis_checker.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef BILINEAR_IMAGE_SCALER_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bilinear_image_scaler: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bilinear_image_scaler: assertion failed");

`endif

@@ hdl/bis_pkg.sv @@
// Shared types and constants of the bilinear image scaler.
// Used by the controller, the datapath and the top level; depends on nothing.
package bis_pkg;

    localparam int SRC_HEIGHT = 256;
    localparam int SRC_WIDTH  = 256;
    localparam int FRAC_BITS  = 12;

    localparam int COORD_W  = 12;
    localparam int PIX_W    = 8;
    localparam int SCALE_W  = 16;
    localparam int DEPTH    = SRC_HEIGHT * SRC_WIDTH;
    localparam int ROW_W    = $clog2(SRC_HEIGHT);
    localparam int COL_W    = $clog2(SRC_WIDTH);
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int POS_W    = COORD_W + SCALE_W;
    localparam int IPOS_W   = POS_W - FRAC_BITS;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(2048);

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP,
        S_AXIS,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_BLEND_BOT,
        S_BLEND_OUT
    } t_state;

    typedef enum logic [1:0] {
        RD_00,
        RD_01,
        RD_10,
        RD_11
    } t_rd_sel;

    typedef struct packed {
        logic    load_wr;
        logic    capture;
        logic    map;
        logic    axis;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_p0;
        logic    calc_top;
        logic    calc_bot;
        logic    calc_out;
    } t_dp_cmd;

endpackage

@@ hdl/bis_ctrl.sv @@
// Sequencing state machine of the bilinear image scaler.
// Depends on bis_pkg; drives the datapath through a command struct.
module bis_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_req_type,
    output logic             o_busy,
    output bis_pkg::t_dp_cmd o_cmd
);

    bis_pkg::t_state r_state;
    bis_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bis_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.rd_sel = bis_pkg::RD_00;
        unique case (r_state)
            bis_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_req_type == bis_pkg::REQ_SAMPLE) begin
                        o_cmd.capture = 1'b1;
                        n_state       = bis_pkg::S_MAP;
                    end else begin
                        o_cmd.load_wr = 1'b1;
                    end
                end
            end
            bis_pkg::S_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = bis_pkg::S_AXIS;
            end
            bis_pkg::S_AXIS: begin
                o_cmd.axis = 1'b1;
                n_state    = bis_pkg::S_RD0;
            end
            bis_pkg::S_RD0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = bis_pkg::RD_00;
                n_state      = bis_pkg::S_RD1;
            end
            bis_pkg::S_RD1: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = bis_pkg::RD_01;
                o_cmd.cap_p0 = 1'b1;
                n_state      = bis_pkg::S_RD2;
            end
            bis_pkg::S_RD2: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = bis_pkg::RD_10;
                o_cmd.calc_top = 1'b1;
                n_state        = bis_pkg::S_RD3;
            end
            bis_pkg::S_RD3: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = bis_pkg::RD_11;
                o_cmd.cap_p0 = 1'b1;
                n_state      = bis_pkg::S_BLEND_BOT;
            end
            bis_pkg::S_BLEND_BOT: begin
                o_cmd.calc_bot = 1'b1;
                n_state        = bis_pkg::S_BLEND_OUT;
            end
            bis_pkg::S_BLEND_OUT: begin
                o_cmd.calc_out = 1'b1;
                n_state        = bis_pkg::S_IDLE;
            end
            default: begin
                n_state = bis_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != bis_pkg::S_IDLE);

endmodule

@@ hdl/bis_datapath.sv @@
// Datapath of the bilinear image scaler: scale register, frame store,
// coordinate mapping and blending. Depends on bis_pkg; steered by bis_ctrl.
module bis_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bis_pkg::t_dp_cmd              i_cmd,
    input  logic                          i_cfg_wr_en,
    input  logic [bis_pkg::SCALE_W-1:0]   i_cfg_wr_data,
    input  logic [bis_pkg::COORD_W-1:0]   i_row,
    input  logic [bis_pkg::COORD_W-1:0]   i_col,
    input  logic [bis_pkg::PIX_W-1:0]     i_pixel,
    output logic                          o_valid,
    output logic [bis_pkg::PIX_W-1:0]     o_value,
    output logic                          o_clamped
);

    function automatic logic [bis_pkg::PIX_W-1:0] f_blend(
        input logic [bis_pkg::PIX_W-1:0]     a,
        input logic [bis_pkg::PIX_W-1:0]     b,
        input logic [bis_pkg::FRAC_BITS-1:0] f
    );
        logic signed [bis_pkg::PIX_W:0]                     diff;
        logic signed [bis_pkg::PIX_W+bis_pkg::FRAC_BITS+1:0] prod;
        logic signed [bis_pkg::PIX_W+bis_pkg::FRAC_BITS+1:0] shifted;
        diff    = $signed({1'b0, b}) - $signed({1'b0, a});
        prod    = diff * $signed({1'b0, f});
        shifted = prod >>> bis_pkg::FRAC_BITS;
        return a + shifted[bis_pkg::PIX_W-1:0];
    endfunction

    logic [bis_pkg::PIX_W-1:0] r_mem [0:bis_pkg::DEPTH-1];

    logic [bis_pkg::SCALE_W-1:0]   r_scale;
    logic [bis_pkg::COORD_W-1:0]   r_row;
    logic [bis_pkg::COORD_W-1:0]   r_col;
    logic [bis_pkg::POS_W-1:0]     r_pos_r;
    logic [bis_pkg::POS_W-1:0]     r_pos_c;
    logic [bis_pkg::ROW_W-1:0]     r_r0;
    logic [bis_pkg::ROW_W-1:0]     r_r1;
    logic [bis_pkg::COL_W-1:0]     r_c0;
    logic [bis_pkg::COL_W-1:0]     r_c1;
    logic [bis_pkg::FRAC_BITS-1:0] r_fr;
    logic [bis_pkg::FRAC_BITS-1:0] r_fc;
    logic                          r_clamp;
    logic [bis_pkg::PIX_W-1:0]     r_rd_data;
    logic [bis_pkg::PIX_W-1:0]     r_p0;
    logic [bis_pkg::PIX_W-1:0]     r_top;
    logic [bis_pkg::PIX_W-1:0]     r_bot;
    logic                          r_valid;
    logic [bis_pkg::PIX_W-1:0]     r_value;
    logic                          r_clamped;

    logic [bis_pkg::IPOS_W-1:0] ip_r;
    logic [bis_pkg::IPOS_W-1:0] ip_c;
    logic                       over_r;
    logic                       over_c;
    logic [bis_pkg::ROW_W-1:0]  n_r0;
    logic [bis_pkg::COL_W-1:0]  n_c0;
    logic                       wr_in_range;
    logic [bis_pkg::ADDR_W-1:0] wr_addr;
    logic [bis_pkg::ROW_W-1:0]  rd_row;
    logic [bis_pkg::COL_W-1:0]  rd_col;
    logic [bis_pkg::ADDR_W-1:0] rd_addr;

    localparam logic [bis_pkg::ROW_W-1:0] LastRow = bis_pkg::ROW_W'(bis_pkg::SRC_HEIGHT - 1);
    localparam logic [bis_pkg::COL_W-1:0] LastCol = bis_pkg::COL_W'(bis_pkg::SRC_WIDTH - 1);

    assign wr_in_range = (32'(i_row) < 32'(bis_pkg::SRC_HEIGHT)) &&
                         (32'(i_col) < 32'(bis_pkg::SRC_WIDTH));
    assign wr_addr = bis_pkg::ADDR_W'(i_row[bis_pkg::ROW_W-1:0])
                     * bis_pkg::ADDR_W'(bis_pkg::SRC_WIDTH)
                     + bis_pkg::ADDR_W'(i_col[bis_pkg::COL_W-1:0]);

    always_comb begin
        case (i_cmd.rd_sel)
            bis_pkg::RD_00: begin
                rd_row = r_r0;
                rd_col = r_c0;
            end
            bis_pkg::RD_01: begin
                rd_row = r_r0;
                rd_col = r_c1;
            end
            bis_pkg::RD_10: begin
                rd_row = r_r1;
                rd_col = r_c0;
            end
            default: begin
                rd_row = r_r1;
                rd_col = r_c1;
            end
        endcase
    end

    assign rd_addr = bis_pkg::ADDR_W'(rd_row) * bis_pkg::ADDR_W'(bis_pkg::SRC_WIDTH)
                     + bis_pkg::ADDR_W'(rd_col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && wr_in_range) begin
            r_mem[wr_addr] <= i_pixel;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign ip_r   = r_pos_r[bis_pkg::POS_W-1:bis_pkg::FRAC_BITS];
    assign ip_c   = r_pos_c[bis_pkg::POS_W-1:bis_pkg::FRAC_BITS];
    assign over_r = ip_r > bis_pkg::IPOS_W'(bis_pkg::SRC_HEIGHT - 1);
    assign over_c = ip_c > bis_pkg::IPOS_W'(bis_pkg::SRC_WIDTH - 1);
    assign n_r0   = over_r ? LastRow : ip_r[bis_pkg::ROW_W-1:0];
    assign n_c0   = over_c ? LastCol : ip_c[bis_pkg::COL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= bis_pkg::SCALE_RESET;
        end else if (i_cfg_wr_en) begin
            r_scale <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_row <= i_row;
            r_col <= i_col;
        end
        if (i_cmd.map) begin
            r_pos_r <= bis_pkg::POS_W'(r_row) * bis_pkg::POS_W'(r_scale);
            r_pos_c <= bis_pkg::POS_W'(r_col) * bis_pkg::POS_W'(r_scale);
        end
        if (i_cmd.axis) begin
            r_r0    <= n_r0;
            r_c0    <= n_c0;
            r_r1    <= (n_r0 == LastRow) ? n_r0 : n_r0 + 1'b1;
            r_c1    <= (n_c0 == LastCol) ? n_c0 : n_c0 + 1'b1;
            r_fr    <= over_r ? '0 : r_pos_r[bis_pkg::FRAC_BITS-1:0];
            r_fc    <= over_c ? '0 : r_pos_c[bis_pkg::FRAC_BITS-1:0];
            r_clamp <= over_r | over_c;
        end
        if (i_cmd.cap_p0) begin
            r_p0 <= r_rd_data;
        end
        if (i_cmd.calc_top) begin
            r_top <= f_blend(r_p0, r_rd_data, r_fc);
        end
        if (i_cmd.calc_bot) begin
            r_bot <= f_blend(r_p0, r_rd_data, r_fc);
        end
        if (i_cmd.calc_out) begin
            r_value   <= f_blend(r_top, r_bot, r_fr);
            r_clamped <= r_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.calc_out;
        end
    end

    assign o_valid   = r_valid;
    assign o_value   = r_value;
    assign o_clamped = r_clamped;

endmodule

@@ hdl/bilinear_image_scaler.sv @@
// Bilinear image scaler, top level: controller plus datapath.
// Depends on bis_pkg, bis_ctrl and bis_datapath.
//
// A transaction is taken at a clock edge where i_start is high and o_busy is low.
// A load transaction writes one pixel of the frame store in that cycle, gives no
// result and leaves o_busy low, so loads may follow in every cycle. A sample
// transaction holds o_busy high while it multiplies both coordinates by the
// inverse scale, clamps and splits them, then goes through four reads of the
// single-ported frame store and two blend steps. The result then appears with
// o_valid for one cycle, in which the next transaction may already be taken;
// a new sample is taken only once the last has given its result. The receiver
// cannot hold results off. The frame store is not cleared; read only pixels that
// have been loaded. The inverse scale may be written only while the block is idle.
module bilinear_image_scaler (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic                        i_cfg_wr_en,
    input  logic [bis_pkg::SCALE_W-1:0] i_cfg_wr_data,
    input  logic                        i_req_type,
    input  logic [bis_pkg::COORD_W-1:0] i_row,
    input  logic [bis_pkg::COORD_W-1:0] i_col,
    input  logic [bis_pkg::PIX_W-1:0]   i_pixel,
    output logic                        o_valid,
    output logic [bis_pkg::PIX_W-1:0]   o_value,
    output logic                        o_clamped
);

    bis_pkg::t_dp_cmd cmd;

    bis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req_type),
        .o_busy     (o_busy),
        .o_cmd      (cmd)
    );

    bis_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_pixel       (i_pixel),
        .o_valid       (o_valid),
        .o_value       (o_value),
        .o_clamped     (o_clamped)
    );

endmodule

@@ hdl/bis_checker.sv @@
// Port-level checker of the bilinear image scaler, bound to the top level.
// Depends on bilinear_image_scaler_defines.svh for its assertion macros.
`include "bilinear_image_scaler_defines.svh"

module bis_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic i_req_type,
    input logic o_busy,
    input logic o_valid
);

    // A result is only ever shown once the block has gone idle again.
    `BIS_ASSERT_SAME(a_valid_idle, i_clk, i_rst_n, o_valid, !o_busy)

    `BIS_ASSERT_NEXT(a_valid_single, i_clk, i_rst_n, o_valid, !o_valid)

    // A load transaction never makes the block busy.
    `BIS_ASSERT_NEXT(a_load_no_busy, i_clk, i_rst_n,
        i_start && !o_busy && !i_req_type, !o_busy && !o_valid)

    // A sample transaction occupies the block in the following cycle.
    `BIS_ASSERT_NEXT(a_sample_busy, i_clk, i_rst_n,
        i_start && !o_busy && i_req_type, o_busy)

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_start    (i_start),
    .i_req_type (i_req_type),
    .o_busy     (o_busy),
    .o_valid    (o_valid)
);
